@@ rtl/assert_macros.svh @@
// Assertion macros shared by the cache RTL.
// Each macro checks on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a property holds at every clock edge.
`define FEC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that the consequent holds in the cycle after the trigger.
`define FEC_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);
`endif

@@ rtl/fec_pkg.sv @@
// Shared types and constants of the FIFO-evicting cache.
// Used by the controller, the datapath and the top level.
package fec_pkg;

    localparam int RING_DEPTH_DEF = 64;

    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 64;
    localparam int SIZE_W   = 40;
    localparam int HANDLE_W = 32;
    localparam int COUNT_W  = 6;
    localparam int BYTES_W  = 41;
    localparam int STAT_W   = 32;
    localparam int LIMIT_W  = 6;
    localparam int BUDGET_W = 21;
    localparam int MIB_SHIFT = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 184;
    localparam int SLOT_W = KEY_W + SIZE_W + HANDLE_W;

    // Request codes
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ERASE  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUDGET_MIB  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STAT_ENABLE = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_step;
        logic scan_clear;
        logic ev_issue;
        logic ev_apply;
        logic ins_write;
        logic apply;
        logic out_load;
    } fec_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic ins_allowed;
        logic evict_needed;
        logic ring_empty;
        logic scan_done;
        logic key_found;
        logic out_busy;
    } fec_status_t;

endpackage

@@ rtl/fec_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/fec_ctrl.sv @@
// Request sequencer of the FIFO-evicting cache.
// Depends on fec_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fec_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  fec_pkg::fec_status_t status,
    output fec_pkg::fec_cmd_t    cmd
);
    import fec_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DISP, ST_CHECK, ST_EVDAT, ST_CLEAR, ST_SEARCH, ST_APPLY, ST_FIN
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Decode commands and next state
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                if (status.func == FUNC_INSERT)
                begin
                    state_next = status.ins_allowed ? ST_CHECK : ST_FIN;
                end
                else if (status.func inside {FUNC_FIND, FUNC_ERASE})
                begin
                    cmd.scan_init = 1'b1;
                    state_next = ST_SEARCH;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_CHECK:
            begin
                if (status.evict_needed && !status.ring_empty)
                begin
                    cmd.ev_issue = 1'b1;
                    state_next = ST_EVDAT;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_EVDAT:
            begin
                cmd.ev_apply = 1'b1;
                cmd.scan_init = 1'b1;
                state_next = ST_CLEAR;
            end
            ST_CLEAR:
            begin
                cmd.scan_step = 1'b1;
                cmd.scan_clear = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_SEARCH:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                cmd.apply = 1'b1;
                cmd.ins_write = (status.func == FUNC_INSERT) && !status.key_found;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `FEC_ASSERT_NEXT(a_accept_dispatch, s_tvalid && s_tready, state_reg == ST_DISP,
        "accepted word not dispatched")
endmodule

@@ rtl/fec_dp.sv @@
// Datapath of the FIFO-evicting cache: slot RAM, live bits, ring pointers,
// byte total, counters, configuration and output register.
// Depends on fec_pkg, fec_ram and assert_macros.svh.
`include "assert_macros.svh"
module fec_dp #(
    parameter int RING_DEPTH = fec_pkg::RING_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [fec_pkg::FUNC_W-1:0]      in_func,
    input  logic [fec_pkg::IN_DATA_W-1:0]   in_data,
    input  logic                            cfg_we,
    input  logic [fec_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fec_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  fec_pkg::fec_cmd_t               cmd,
    output fec_pkg::fec_status_t            status,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            out_ok,
    output logic [fec_pkg::OUT_DATA_W-1:0]  out_data
);
    import fec_pkg::*;

    localparam int AW   = $clog2(RING_DEPTH);
    localparam int CW   = $clog2(RING_DEPTH + 1);
    localparam int LW   = (AW > LIMIT_W) ? AW : LIMIT_W;
    localparam logic [AW-1:0] PTR_LAST = AW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] SCAN_END = CW'(RING_DEPTH);

    // Request and configuration registers
    logic [FUNC_W-1:0]   func_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [BUDGET_W-1:0] budget_reg;
    logic                stat_en_reg;

    // Ring state
    logic [RING_DEPTH-1:0] live_reg;
    logic [AW-1:0]         head_reg, tail_reg;
    logic [BYTES_W-1:0]    bytes_reg;
    logic [STAT_W-1:0]     hits_reg, misses_reg;

    // Scan state
    logic [CW-1:0]       scan_cnt_reg;
    logic                cmp_vld_reg;
    logic [AW-1:0]       cmp_idx_reg;
    logic                found_reg;
    logic [AW-1:0]       found_idx_reg;
    logic [SIZE_W-1:0]   found_size_reg;
    logic [HANDLE_W-1:0] found_handle_reg;
    logic [KEY_W-1:0]    ev_key_reg;

    // Result registers
    logic                res_ok_reg;
    logic [HANDLE_W-1:0] res_fh_reg;
    logic [SIZE_W-1:0]   res_fs_reg;
    logic                out_valid_reg;
    logic                out_ok_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // Slot RAM: {handle, size, key}
    logic              ram_we;
    logic [AW-1:0]     ram_raddr;
    logic [SLOT_W-1:0] ram_wdata, ram_rdata;
    logic [KEY_W-1:0]    rd_key;
    logic [SIZE_W-1:0]   rd_size;
    logic [HANDLE_W-1:0] rd_handle;

    assign ram_we    = cmd.ins_write;
    assign ram_wdata = {handle_reg, size_reg, key_reg};
    assign ram_raddr = cmd.ev_issue ? head_reg : scan_cnt_reg[AW-1:0];
    assign rd_key    = ram_rdata[KEY_W-1:0];
    assign rd_size   = ram_rdata[KEY_W +: SIZE_W];
    assign rd_handle = ram_rdata[KEY_W+SIZE_W +: HANDLE_W];

    fec_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (RING_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Derived values
    logic [AW-1:0]       count;
    logic [LW-1:0]       limit_eff;
    logic [BYTES_W-1:0]  budget;
    logic [BYTES_W:0]    bytes_sum;
    logic                cmp_match;
    logic [LW-1:0]       count_wide;

    assign count = (tail_reg >= head_reg) ? (tail_reg - head_reg)
                                          : AW'((CW)'(tail_reg) + SCAN_END - (CW)'(head_reg));
    assign limit_eff = (LW'(limit_reg) > LW'(PTR_LAST)) ? LW'(PTR_LAST) : LW'(limit_reg);
    assign budget    = {budget_reg, {MIB_SHIFT{1'b0}}};
    assign bytes_sum = {1'b0, bytes_reg} + {2'b0, size_reg};
    assign count_wide = LW'(count);
    assign cmp_match = cmp_vld_reg && live_reg[cmp_idx_reg]
                    && (rd_key == (cmd.scan_clear ? ev_key_reg : key_reg));

    assign status.func         = func_reg;
    assign status.ins_allowed  = ({1'b0, size_reg} <= budget) && (limit_eff != '0);
    assign status.evict_needed = (count_wide >= limit_eff) || (bytes_sum > {1'b0, budget});
    assign status.ring_empty   = (head_reg == tail_reg);
    assign status.scan_done    = (scan_cnt_reg == SCAN_END) && !cmp_vld_reg;
    assign status.key_found    = found_reg;
    assign status.out_busy     = out_valid_reg && !out_ready;

    // Capture request and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= '0;
            budget_reg  <= '0;
            stat_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENTRY_LIMIT: limit_reg   <= cfg_data[LIMIT_W-1:0];
                REG_BUDGET_MIB:  budget_reg  <= cfg_data[BUDGET_W-1:0];
                REG_STAT_ENABLE: stat_en_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= in_func;
            key_reg    <= in_data[KEY_W-1:0];
            size_reg   <= in_data[KEY_W +: SIZE_W];
            handle_reg <= in_data[KEY_W+SIZE_W +: HANDLE_W];
        end
        if (cmd.ev_apply)
        begin
            ev_key_reg <= rd_key;
        end
        if (cmd.scan_step && cmp_match && !found_reg && !cmd.scan_clear)
        begin
            found_idx_reg    <= cmp_idx_reg;
            found_size_reg   <= rd_size;
            found_handle_reg <= rd_handle;
        end
    end

    // Advance the scan: issue addresses, compare each in the following cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            cmp_idx_reg  <= '0;
            found_reg    <= 1'b0;
        end
        else if (cmd.scan_init)
        begin
            scan_cnt_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            found_reg    <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            cmp_vld_reg <= (scan_cnt_reg != SCAN_END);
            cmp_idx_reg <= scan_cnt_reg[AW-1:0];
            if (scan_cnt_reg != SCAN_END)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            if (cmp_match && !cmd.scan_clear)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // Update ring state, live bits and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg   <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            bytes_reg  <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_STAT_ENABLE)
            begin
                hits_reg   <= '0;
                misses_reg <= '0;
            end
            if (cmd.ev_apply)
            begin
                head_reg  <= (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                bytes_reg <= ({1'b0, rd_size} > bytes_reg) ? '0
                                                           : bytes_reg - {1'b0, rd_size};
            end
            if (cmd.scan_step && cmd.scan_clear && cmp_match)
            begin
                live_reg[cmp_idx_reg] <= 1'b0;
            end
            if (cmd.ins_write)
            begin
                live_reg[tail_reg] <= 1'b1;
                tail_reg  <= (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                bytes_reg <= bytes_sum[BYTES_W-1:0];
            end
            if (cmd.apply && func_reg == FUNC_FIND && stat_en_reg)
            begin
                if (found_reg)
                begin
                    hits_reg <= hits_reg + 1'b1;
                end
                else
                begin
                    misses_reg <= misses_reg + 1'b1;
                end
            end
            if (cmd.apply && func_reg == FUNC_ERASE && found_reg)
            begin
                live_reg[found_idx_reg] <= 1'b0;
            end
        end
    end

    // Form the result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_ok_reg <= 1'b0;
            res_fh_reg <= '0;
            res_fs_reg <= '0;
        end
        else if (cmd.apply)
        begin
            res_ok_reg <= (func_reg == FUNC_INSERT) ? !found_reg : found_reg;
            if (func_reg == FUNC_FIND && found_reg)
            begin
                res_fh_reg <= found_handle_reg;
                res_fs_reg <= found_size_reg;
            end
        end
    end

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_ok_reg   <= res_ok_reg;
            out_data_reg <= {1'b0, misses_reg, hits_reg, bytes_reg,
                             count_wide[COUNT_W-1:0], res_fs_reg, res_fh_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ok    = out_ok_reg;
    assign out_data  = out_data_reg;

    `FEC_ASSERT(a_empty_no_bytes, (head_reg != tail_reg) || (bytes_reg == '0),
        "empty ring holds bytes")
    `FEC_ASSERT(a_no_dup_insert, !cmd.ins_write || !found_reg,
        "insert written over a live key")
endmodule

@@ rtl/fifo_evicting_cache.sv @@
// FIFO-evicting key/value cache, top level. Depends on fec_pkg, fec_ctrl, fec_dp.
// A find or erase scans every slot, one key compare per cycle through the slot RAM
// read port; an insert first evicts from the head while over a limit, then scans; a
// refused insert or unknown request skips the scan. Throughput: one request at a
// time; the next word is accepted once the result is registered. Reset clears
// pointers, live bits, counters and configuration at once.
module fifo_evicting_cache #(
    parameter int RING_DEPTH = fec_pkg::RING_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fec_pkg::IN_DATA_W-1:0]   s_tdata,  // key, value_size, value_handle
    input  logic [fec_pkg::FUNC_W-1:0]      s_tuser,  // func
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fec_pkg::OUT_DATA_W-1:0]  m_tdata,  // found_handle, found_size,
                                                      // entry_count, bytes_used,
                                                      // hits, misses, pad
    output logic                            m_tuser,  // ok
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fec_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fec_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fec_pkg::*;

    fec_cmd_t    cmd;
    fec_status_t status;

    assign cfg_ready = 1'b1;

    fec_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fec_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_func   (s_tuser),
        .in_data   (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_ok    (m_tuser),
        .out_data  (m_tdata)
    );
endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for fifo_evicting_cache: a directed table, then random phases.
// Depends on fec_pkg and the cache RTL. A built-in cache predictor checks every result.
module testbench;
    import fec_pkg::*;

    localparam int DEPTH     = 64;
    localparam int RAND_ITEMS = 550;
    localparam int CYCLE_LIMIT = 20000000;
    localparam logic [1:0] FUNC_BAD = 2'd3;

    typedef struct {
        logic [FUNC_W-1:0]   func;
        logic [KEY_W-1:0]    key;
        logic [SIZE_W-1:0]   size;
        logic [HANDLE_W-1:0] handle;
    } request_t;

    typedef struct {
        logic                ok;
        logic [HANDLE_W-1:0] fh;
        logic [SIZE_W-1:0]   fs;
        logic [COUNT_W-1:0]  cnt;
        logic [BYTES_W-1:0]  bytes;
        logic [STAT_W-1:0]   hits;
        logic [STAT_W-1:0]   misses;
    } response_t;

    // One directed row: a register write, or a request with an optional typed ok
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        request_t              req;
        bit                    has_ok;
        logic                  ok;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [FUNC_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    fifo_evicting_cache uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Predictor state
    logic [KEY_W-1:0]    p_key [DEPTH];
    logic [SIZE_W-1:0]   p_size [DEPTH];
    logic [HANDLE_W-1:0] p_handle [DEPTH];
    bit                  p_live [DEPTH];
    int unsigned p_head, p_tail;
    logic [BYTES_W-1:0] p_bytes;
    logic [STAT_W-1:0] p_hits, p_misses;
    logic [LIMIT_W-1:0] p_limit;
    logic [BUDGET_W-1:0] p_budget;
    logic p_stat;

    response_t pending_results[$];
    row_t rows[$];
    int errors = 0;
    int cycles = 0;
    logic [KEY_W-1:0] key_pool [16];

    // Append one row to the directed table
    function automatic void add_row(bit is_cfg, logic [CFG_IDX_W-1:0] idx,
                                    logic [CFG_DATA_W-1:0] val, request_t req,
                                    bit has_ok, logic ok);
        row_t x;
        x = '{is_cfg, idx, val, req, has_ok, ok};
        rows.insert(rows.size(), x);
    endfunction

    function automatic int unsigned ring_fill();
        return (p_tail + DEPTH - p_head) % DEPTH;
    endfunction

    function automatic int find_live(logic [KEY_W-1:0] k);
        for (int i = 0; i < DEPTH; i++)
            if (p_live[i] && p_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic void drop_oldest();
        int unsigned h;
        logic [KEY_W-1:0] k;
        h = p_head;
        if (h == p_tail)
            return;
        p_head = (h + 1) % DEPTH;
        p_bytes = ({1'b0, p_size[h]} > p_bytes) ? '0 : p_bytes - p_size[h];
        k = p_key[h];
        for (int i = 0; i < DEPTH; i++)
            if (p_live[i] && p_key[i] == k)
                p_live[i] = 0;
    endfunction

    function automatic response_t cache_predict(request_t r);
        response_t e;
        logic [BYTES_W:0] budget;
        int unsigned lim;
        int idx;
        e = '{default: '0};
        budget = {1'b0, p_budget, 20'b0};
        lim = (p_limit > DEPTH - 1) ? DEPTH - 1 : p_limit;
        case (r.func)
            FUNC_INSERT: begin
                if (r.size <= budget && lim >= 1) begin
                    for (int g = 0; g <= DEPTH; g++) begin
                        if (ring_fill() >= lim || ({1'b0, p_bytes} + r.size) > budget)
                            drop_oldest();
                        else
                            break;
                    end
                    if (find_live(r.key) < 0) begin
                        p_key[p_tail] = r.key;
                        p_size[p_tail] = r.size;
                        p_handle[p_tail] = r.handle;
                        p_live[p_tail] = 1;
                        p_tail = (p_tail + 1) % DEPTH;
                        p_bytes = p_bytes + r.size;
                        e.ok = 1;
                    end
                end
            end
            FUNC_FIND: begin
                idx = find_live(r.key);
                if (idx >= 0) begin
                    e.ok = 1;
                    e.fh = p_handle[idx];
                    e.fs = p_size[idx];
                    if (p_stat) p_hits++;
                end else if (p_stat) begin
                    p_misses++;
                end
            end
            FUNC_ERASE: begin
                idx = find_live(r.key);
                if (idx >= 0) begin
                    p_live[idx] = 0;
                    e.ok = 1;
                end
            end
            default: ;
        endcase
        e.cnt = COUNT_W'(ring_fill());
        e.bytes = p_bytes;
        e.hits = p_hits;
        e.misses = p_misses;
        return e;
    endfunction

    // Wait until every expected result has come back
    task automatic drain();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        s_tvalid <= 1'b0;
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ENTRY_LIMIT: p_limit = val[LIMIT_W-1:0];
            REG_BUDGET_MIB:  p_budget = val[BUDGET_W-1:0];
            REG_STAT_ENABLE: begin
                p_stat = val[0];
                p_hits = '0;
                p_misses = '0;
            end
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Send one word; a typed ok, when given, replaces the predicted one
    task automatic send_request(request_t r, bit has_ok, logic ok);
        int gap;
        response_t e;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {r.handle, r.size, r.key};
        s_tuser <= r.func;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        e = cache_predict(r);
        if (has_ok) e.ok = ok;
        pending_results.insert(pending_results.size(), e);
    endtask

    function automatic request_t random_request(logic [SIZE_W-1:0] size_cap);
        request_t r;
        int sel;
        sel = $urandom_range(0, 99);
        r.func = (sel < 45) ? FUNC_INSERT : (sel < 80) ? FUNC_FIND :
                 (sel < 95) ? FUNC_ERASE : FUNC_BAD;
        r.key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                            : key_pool[$urandom_range(0, 15)];
        sel = $urandom_range(0, 19);
        if (sel == 0)
            r.size = SIZE_W'({$urandom, $urandom});
        else if (sel == 1)
            r.size = '0;
        else
            r.size = SIZE_W'({$urandom, $urandom} % (size_cap + 1));
        r.handle = $urandom;
        return r;
    endfunction

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Accept results with random stalls and compare against the oldest expectation
    initial
    begin
        response_t e;
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 3);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            if (pending_results.size() == 0)
            begin
                $error("result word with no expectation waiting");
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (m_tuser !== e.ok)
                    begin $error("ok: expected %0h, got %0h", e.ok, m_tuser); errors++; end
                if (m_tdata[31:0] !== e.fh)
                    begin $error("found_handle: expected %0h, got %0h", e.fh, m_tdata[31:0]);
                    errors++; end
                if (m_tdata[71:32] !== e.fs)
                    begin $error("found_size: expected %0h, got %0h", e.fs, m_tdata[71:32]);
                    errors++; end
                if (m_tdata[77:72] !== e.cnt)
                    begin $error("entry_count: expected %0d, got %0d", e.cnt, m_tdata[77:72]);
                    errors++; end
                if (m_tdata[118:78] !== e.bytes)
                    begin $error("bytes_used: expected %0h, got %0h", e.bytes, m_tdata[118:78]);
                    errors++; end
                if (m_tdata[150:119] !== e.hits)
                    begin $error("hit_total: expected %0d, got %0d", e.hits, m_tdata[150:119]);
                    errors++; end
                if (m_tdata[182:151] !== e.misses)
                    begin $error("miss_total: expected %0d, got %0d", e.misses,
                        m_tdata[182:151]); errors++; end
            end
        end
    end

    // Main sequence
    initial
    begin
        request_t r;
        logic [KEY_W-1:0] ka, kb;
        logic [LIMIT_W-1:0] lims [5];
        logic [BUDGET_W-1:0] buds [5];
        logic [SIZE_W-1:0] caps [5];

        lims = '{6'd63, 6'd1, 6'd5, 6'd63, 6'd3};
        buds = '{21'h1FFFFF, 21'd1, 21'd4, 21'd2, 21'd1048576};
        caps = '{40'd4194304, 40'd1048576, 40'd2097152, 40'd1048576, 40'd3145728};
        for (int i = 0; i < DEPTH; i++) p_live[i] = 0;
        p_head = 0; p_tail = 0; p_bytes = '0; p_hits = '0; p_misses = '0;
        p_limit = '0; p_budget = '0; p_stat = 1'b0;
        for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
        ka = key_pool[0];
        kb = key_pool[1];

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: reset limits, duplicates, erase, oversize, budget cut, bad func
        add_row(0, 0, 0, '{FUNC_INSERT, ka, 40'd1, 32'd1}, 1, 1'b0);
        add_row(1, REG_ENTRY_LIMIT, 21'd4, '{0, 0, 0, 0}, 0, 0);
        add_row(1, REG_BUDGET_MIB, 21'd0, '{0, 0, 0, 0}, 0, 0);
        add_row(0, 0, 0, '{FUNC_INSERT, ka, 40'd0, 32'd2}, 1, 1'b1);
        add_row(0, 0, 0, '{FUNC_INSERT, kb, 40'd1, 32'd3}, 1, 1'b0);
        add_row(1, REG_BUDGET_MIB, 21'd8, '{0, 0, 0, 0}, 0, 0);
        add_row(1, REG_STAT_ENABLE, 21'd1, '{0, 0, 0, 0}, 0, 0);
        add_row(0, 0, 0, '{FUNC_INSERT, ka, 40'd1048576, 32'd4}, 1, 1'b0);
        add_row(0, 0, 0, '{FUNC_FIND, ka, 40'd0, 32'd0}, 1, 1'b1);
        add_row(0, 0, 0, '{FUNC_FIND, kb, 40'd0, 32'd0}, 1, 1'b0);
        add_row(0, 0, 0, '{FUNC_ERASE, ka, 40'd0, 32'd0}, 1, 1'b1);
        add_row(0, 0, 0, '{FUNC_ERASE, ka, 40'd0, 32'd0}, 1, 1'b0);
        add_row(0, 0, 0, '{FUNC_INSERT, ka, 40'd1048576, 32'd5}, 1, 1'b1);
        add_row(0, 0, 0, '{FUNC_INSERT, kb, 40'd9437184, 32'd6}, 1, 1'b0);
        add_row(0, 0, 0, '{FUNC_INSERT, kb, 40'd8388608, 32'd7}, 1, 1'b1);
        add_row(0, 0, 0, '{FUNC_INSERT, '1, 40'd0, '1}, 1, 1'b1);
        add_row(0, 0, 0, '{FUNC_INSERT, '0, 40'd0, 32'd8}, 1, 1'b1);
        add_row(0, 0, 0, '{FUNC_INSERT, key_pool[2], 40'd0, 32'd9}, 0, 0);
        add_row(0, 0, 0, '{FUNC_INSERT, key_pool[3], 40'd0, 32'd10}, 0, 0);
        add_row(0, 0, 0, '{FUNC_FIND, '1, 40'd0, 32'd0}, 0, 0);
        add_row(0, 0, 0, '{FUNC_BAD, '1, '1, '1}, 1, 1'b0);
        add_row(1, REG_BUDGET_MIB, 21'd1, '{0, 0, 0, 0}, 0, 0);
        add_row(0, 0, 0, '{FUNC_INSERT, key_pool[4], 40'd1048576, 32'd11}, 1, 1'b1);
        add_row(1, REG_ENTRY_LIMIT, 21'd63, '{0, 0, 0, 0}, 0, 0);
        add_row(1, REG_BUDGET_MIB, 21'h1FFFFF, '{0, 0, 0, 0}, 0, 0);
        add_row(0, 0, 0, '{FUNC_INSERT, key_pool[5], '1, '1}, 1, 1'b1);
        add_row(0, 0, 0, '{FUNC_FIND, key_pool[5], 40'd0, 32'd0}, 1, 1'b1);

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
                write_reg(rows[i].idx, rows[i].val);
            else
                send_request(rows[i].req, rows[i].has_ok, rows[i].ok);
        end

        // Random phases, one register setting each, extremes among them
        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(REG_ENTRY_LIMIT, CFG_DATA_W'(lims[ph]));
            write_reg(REG_BUDGET_MIB, CFG_DATA_W'(buds[ph]));
            write_reg(REG_STAT_ENABLE, CFG_DATA_W'(ph % 2));
            for (int n = 0; n < RAND_ITEMS / 5; n++)
            begin
                r = random_request(caps[ph]);
                send_request(r, 0, 0);
                // Hold off once per phase until the pipeline is empty
                if (n == 40)
                begin
                    s_tvalid <= 1'b0;
                    drain();
                end
            end
        end
        s_tvalid <= 1'b0;

        drain();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/fec_pkg.sv
rtl/fec_ram.sv
rtl/fec_ctrl.sv
rtl/fec_dp.sv
rtl/fifo_evicting_cache.sv
tb/testbench.sv
